[src/pssr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pssr_pkg
// shared types and constants of the pwm soft start regulator
// ----------------------------------------------------------------------------
package pssr_pkg;

	localparam int TICK_PERIOD_DEF = 10;

	localparam int LEVEL_W = 8;
	localparam int DUTY_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [DUTY_W:0]  BAND_WIDTH = 17'd20;
	localparam logic [LEVEL_W:0] UP_STEP    = 9'd4;
	localparam logic [LEVEL_W-1:0] DOWN_STEP = 8'd1;

	typedef enum logic [1:0] {
		CMD_RESTART  = 2'd0,
		CMD_RAISE    = 2'd1,
		CMD_REGULATE = 2'd2,
		CMD_LOAD     = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_LEVEL   = 3'd0,
		REG_MIN_LEVEL   = 3'd1,
		REG_RAMP_STEP   = 3'd2,
		REG_TARGET_DUTY = 3'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [DUTY_W-1:0]  hall_duty;
		logic [LEVEL_W-1:0] load_value;
	} in_word_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] pwm_level;
		logic               adjusted;
	} out_word_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] max_level;
		logic [LEVEL_W-1:0] min_level;
		logic [LEVEL_W-1:0] ramp_step;
		logic [DUTY_W-1:0]  target_duty;
	} cfg_t;

endpackage
`default_nettype wire

[src/pwm_soft_start_regulator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_soft_start_regulator_unit
// tick driven pwm duty keeper with soft start ramp and deadband regulation
// ----------------------------------------------------------------------------
// One word per clock cycle: each accepted word updates the prescaler and duty
// registers in the same cycle and its result lands in an output register,
// so the result appears in the cycle after acceptance. The input is taken while
// the output register is empty or being drained in that cycle, so the block
// sustains one word per cycle when the downstream side keeps taking results.
module pwm_soft_start_regulator_unit #(
	parameter int TICK_PERIOD = pssr_pkg::TICK_PERIOD_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire pssr_pkg::in_word_t                  in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output pssr_pkg::out_word_t                      out_data,
	input  wire logic                                cfg_we,
	input  wire logic [pssr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pssr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CNT_W = $clog2(TICK_PERIOD + 1);

	pssr_pkg::cfg_t                   cfg_q;
	logic                             armed_q;
	logic [CNT_W-1:0]                 count_q;
	logic [pssr_pkg::LEVEL_W-1:0]     duty_q;
	logic                             out_valid_q;
	pssr_pkg::out_word_t              out_data_q;

	logic                             armed_nxt;
	logic [CNT_W-1:0]                 count_nxt;
	pssr_pkg::out_word_t              result;
	logic                             accept;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	pssr_step #(
		.TICK_PERIOD (TICK_PERIOD),
		.CNT_W       (CNT_W)
	) u_step (
		.word      (in_data),
		.cfg       (cfg_q),
		.armed     (armed_q),
		.count     (count_q),
		.duty      (duty_q),
		.armed_nxt (armed_nxt),
		.count_nxt (count_nxt),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_level   <= 8'd255;
			cfg_q.min_level   <= 8'd0;
			cfg_q.ramp_step   <= 8'd1;
			cfg_q.target_duty <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pssr_pkg::REG_MAX_LEVEL:   cfg_q.max_level   <= cfg_data[pssr_pkg::LEVEL_W-1:0];
				pssr_pkg::REG_MIN_LEVEL:   cfg_q.min_level   <= cfg_data[pssr_pkg::LEVEL_W-1:0];
				pssr_pkg::REG_RAMP_STEP:   cfg_q.ramp_step   <= cfg_data[pssr_pkg::LEVEL_W-1:0];
				pssr_pkg::REG_TARGET_DUTY: cfg_q.target_duty <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			count_q     <= '0;
			duty_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				armed_q     <= armed_nxt;
				count_q     <= count_nxt;
				duty_q      <= result.pwm_level;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result;
		end
	end

endmodule
`default_nettype wire

[src/pssr_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pssr_step
// next state of the prescaler and duty for one input word
// ----------------------------------------------------------------------------
module pssr_step #(
	parameter int TICK_PERIOD = pssr_pkg::TICK_PERIOD_DEF,
	parameter int CNT_W       = $clog2(TICK_PERIOD + 1)
) (
	input  wire pssr_pkg::in_word_t                word,
	input  wire pssr_pkg::cfg_t                    cfg,
	input  wire logic                              armed,
	input  wire logic [CNT_W-1:0]                  count,
	input  wire logic [pssr_pkg::LEVEL_W-1:0]      duty,
	output logic                                   armed_nxt,
	output logic [CNT_W-1:0]                       count_nxt,
	output pssr_pkg::out_word_t                    result
);

	localparam logic [CNT_W-1:0] PERIOD = CNT_W'(TICK_PERIOD);

	logic [CNT_W-1:0]                  count_dec;
	logic                              expire;
	logic [pssr_pkg::LEVEL_W:0]        inc;
	logic [pssr_pkg::LEVEL_W:0]        raised_sum;
	logic [pssr_pkg::LEVEL_W-1:0]      raised;
	logic [pssr_pkg::LEVEL_W-1:0]      lowered;
	logic [pssr_pkg::DUTY_W:0]         hall_w;
	logic [pssr_pkg::DUTY_W:0]         tgt_w;
	logic                              above;
	logic                              below;
	logic [pssr_pkg::LEVEL_W-1:0]      duty_nxt;

	always_comb begin
		count_dec = count - CNT_W'(1);
		expire    = armed && (count_dec == '0);

		hall_w = {1'b0, word.hall_duty};
		tgt_w  = {1'b0, cfg.target_duty};
		// band compares kept unsigned by moving the offset to the other side
		above  = hall_w > (tgt_w + pssr_pkg::BAND_WIDTH);
		below  = (hall_w + pssr_pkg::BAND_WIDTH) < tgt_w;

		inc = (pssr_pkg::cmd_t'(word.cmd) == pssr_pkg::CMD_RAISE) ?
			{1'b0, cfg.ramp_step} : pssr_pkg::UP_STEP;
		raised_sum = {1'b0, duty} + inc;
		// saturate: cur + inc must stay strictly below max
		raised = (raised_sum < {1'b0, cfg.max_level}) ?
			raised_sum[pssr_pkg::LEVEL_W-1:0] : cfg.max_level;
		lowered = (duty > cfg.min_level) ? duty - pssr_pkg::DOWN_STEP : cfg.min_level;

		armed_nxt = armed;
		count_nxt = count;
		duty_nxt  = duty;
		unique case (pssr_pkg::cmd_t'(word.cmd))
			pssr_pkg::CMD_RESTART: begin
				armed_nxt = 1'b0;
				count_nxt = '0;
			end
			pssr_pkg::CMD_LOAD: begin
				duty_nxt = word.load_value;
			end
			pssr_pkg::CMD_RAISE, pssr_pkg::CMD_REGULATE: begin
				armed_nxt = 1'b1;
				if (!armed || expire) begin
					count_nxt = PERIOD;
				end else begin
					count_nxt = count_dec;
				end
				if (expire) begin
					if (pssr_pkg::cmd_t'(word.cmd) == pssr_pkg::CMD_RAISE || above) begin
						duty_nxt = raised;
					end else if (below) begin
						duty_nxt = lowered;
					end
				end
			end
			default: begin
			end
		endcase

		result.pwm_level = duty_nxt;
		result.adjusted  = expire && (pssr_pkg::cmd_t'(word.cmd) == pssr_pkg::CMD_RAISE ||
			pssr_pkg::cmd_t'(word.cmd) == pssr_pkg::CMD_REGULATE);
	end

endmodule
`default_nettype wire

[verif/pssr_duty_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pssr_duty_checker
// watches both channels and the register port of the soft start regulator,
// keeps its own copy of prescaler, duty and registers, and compares every
// result word with the duty and adjust flag it predicts
// ----------------------------------------------------------------------------
module pssr_duty_checker #(
	parameter int TICK_PERIOD = pssr_pkg::TICK_PERIOD_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_ready,
	input  wire pssr_pkg::in_word_t              in_data,
	input  wire logic                            out_valid,
	input  wire logic                            out_ready,
	input  wire pssr_pkg::out_word_t             out_data,
	input  wire logic                            cfg_we,
	input  wire logic [pssr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pssr_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                   backlog,
	output int                                   fail_count
);
	import pssr_pkg::*;

	cfg_t               regs;
	logic               armed;
	logic [7:0]         prescale_left;
	logic [LEVEL_W-1:0] duty;
	out_word_t          duty_q[$];
	int                 fails;

	// wide signed compare, so a step above max_level never wraps
	function automatic logic [LEVEL_W-1:0] sat_add(logic [LEVEL_W-1:0] cur, int inc);
		if (int'(cur) < int'(regs.max_level) - inc)
			return cur + LEVEL_W'(inc);
		return regs.max_level;
	endfunction

	function automatic out_word_t next_level(in_word_t w);
		out_word_t r;
		int        hall;
		int        tgt;
		logic      fire;
		fire = 1'b0;
		hall = int'(w.hall_duty);
		tgt  = int'(regs.target_duty);
		case (w.cmd)
			CMD_RESTART: begin
				armed = 1'b0;
				prescale_left = '0;
			end
			CMD_LOAD: begin
				duty = w.load_value;
			end
			default: begin
				if (!armed) begin
					armed = 1'b1;
					prescale_left = 8'(TICK_PERIOD);
				end else begin
					prescale_left = prescale_left - 8'd1;
					if (prescale_left == 8'd0) begin
						prescale_left = 8'(TICK_PERIOD);
						fire = 1'b1;
					end
				end
				if (fire) begin
					if (w.cmd == CMD_RAISE)
						duty = sat_add(duty, int'(regs.ramp_step));
					else if (hall > tgt + int'(BAND_WIDTH))
						duty = sat_add(duty, int'(UP_STEP));
					else if (hall < tgt - int'(BAND_WIDTH))
						duty = (duty > regs.min_level) ? duty - DOWN_STEP : regs.min_level;
				end
			end
		endcase
		r.pwm_level = duty;
		r.adjusted  = fire;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			regs.max_level   = 8'd255;
			regs.min_level   = 8'd0;
			regs.ramp_step   = 8'd1;
			regs.target_duty = 16'd0;
			armed = 1'b0;
			prescale_left = '0;
			duty = '0;
			duty_q.delete();
			fails = 0;
			backlog <= 0;
			fail_count <= 0;
		end else begin
			// results leave before the new word is pushed; they belong to older words
			if (out_valid && out_ready) begin
				if (duty_q.size() == 0) begin
					$error("unexpected result word: pwm_level %0d adjusted %0d",
						out_data.pwm_level, out_data.adjusted);
					fails++;
				end else begin
					want = duty_q.pop_front();
					if (out_data.pwm_level !== want.pwm_level) begin
						$error("pwm_level mismatch: expected %0d, actual %0d",
							want.pwm_level, out_data.pwm_level);
						fails++;
					end
					if (out_data.adjusted !== want.adjusted) begin
						$error("adjusted mismatch: expected %0d, actual %0d",
							want.adjusted, out_data.adjusted);
						fails++;
					end
				end
			end
			if (in_valid && in_ready)
				duty_q.push_back(next_level(in_data));
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_LEVEL:   regs.max_level   = cfg_data[LEVEL_W-1:0];
					REG_MIN_LEVEL:   regs.min_level   = cfg_data[LEVEL_W-1:0];
					REG_RAMP_STEP:   regs.ramp_step   = cfg_data[LEVEL_W-1:0];
					REG_TARGET_DUTY: regs.target_duty = cfg_data[DUTY_W-1:0];
					default: ;
				endcase
			end
			backlog <= duty_q.size();
			fail_count <= fails;
		end
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives restart, raise, regulate and load words into the soft start
// regulator under several register settings and idle profiles; the duty
// checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
	import pssr_pkg::*;

	// index past the last register, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 220;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_word_t              in_data;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    backlog;
	int                    fail_count;
	int                    idle_pct;
	int                    stall_pct;
	logic [DUTY_W-1:0]     cur_target;

	pwm_soft_start_regulator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pssr_duty_checker duty_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.backlog    (backlog),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic in_word_t make_word(cmd_t cmd, logic [DUTY_W-1:0] hall,
			logic [LEVEL_W-1:0] load);
		in_word_t w;
		w.cmd = cmd;
		w.hall_duty = hall;
		w.load_value = load;
		return w;
	endfunction

	// mostly ticks so the prescaler gets through to adjustments,
	// hall values clustered around the deadband edges
	function automatic in_word_t random_word();
		in_word_t w;
		int       pick;
		int       h;
		pick = $urandom_range(99);
		w.hall_duty = DUTY_W'($urandom);
		w.load_value = LEVEL_W'($urandom);
		if (pick < 3) begin
			w.cmd = CMD_RESTART;
		end else if (pick < 10) begin
			w.cmd = CMD_LOAD;
		end else begin
			w.cmd = $urandom_range(1) ? CMD_REGULATE : CMD_RAISE;
			case ($urandom_range(2))
				0: h = int'(cur_target) + int'($urandom_range(50)) - 25;
				1: h = int'(cur_target) + ($urandom_range(1) ? 1 : -1)
					* (20 + int'($urandom_range(1)));
				default: h = int'($urandom_range(65535));
			endcase
			if (h < 0)
				h = 0;
			if (h > 65535)
				h = 65535;
			w.hall_duty = h[DUTY_W-1:0];
		end
		return w;
	endfunction

	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int max_lvl, input int min_lvl, input int step,
			input int target);
		write_reg(REG_MAX_LEVEL, CFG_DATA_W'(max_lvl));
		write_reg(REG_MIN_LEVEL, CFG_DATA_W'(min_lvl));
		write_reg(REG_RAMP_STEP, CFG_DATA_W'(step));
		write_reg(REG_TARGET_DUTY, CFG_DATA_W'(target));
		cur_target = DUTY_W'(target);
	endtask

	initial begin
		int mx;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		cur_target = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// step wider than max, duty loaded above max, target under the band
		configure(200, 10, 255, 15);
		write_reg(REG_SPARE, 16'hffff);
		send_word(make_word(CMD_LOAD, 16'hffff, 8'hff));
		repeat (11) send_word(make_word(CMD_RAISE, 16'h0000, 8'h00));
		send_word(make_word(CMD_RESTART, 16'hffff, 8'hff));
		// hall 0 sits inside a band that reaches below zero
		repeat (11) send_word(make_word(CMD_REGULATE, 16'h0000, 8'h00));
		send_word(make_word(CMD_LOAD, 16'h0000, 8'h00));
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 73;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 73;
				end
				default: begin
					idle_pct = 18;
					stall_pct = 18;
				end
			endcase
			case (phase)
				0: configure(255, 0, 1, 0);
				1: configure(0, 0, 255, 65535);
				2: configure(255, 255, 255, 10);
				3: configure(100, 150, 4, 200);
				default: begin
					mx = $urandom_range(255);
					configure(mx, $urandom_range(mx), $urandom_range(1) ? $urandom_range(8)
						: $urandom_range(255), $urandom_range(65535));
				end
			endcase
			repeat (WORDS_PER_PHASE) send_word(random_word());
			drain();
		end

		repeat (4) @(posedge clk);
		if (fail_count == 0 && backlog == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
